// ===== hw/rtl/bse_pkg.sv =====
// Package for the bounded stack engine: constants, codes and word types.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package bse_pkg;
   localparam int DefaultDepth = 16;
   localparam int CountWidth = 5;

   localparam logic [2:0] FuncPush   = 3'd0;
   localparam logic [2:0] FuncPop    = 3'd1;
   localparam logic [2:0] FuncClear  = 3'd2;
   localparam logic [2:0] FuncSearch = 3'd3;
   localparam logic [2:0] FuncSort   = 3'd4;
   localparam logic [2:0] FuncStats  = 3'd5;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusFull     = 2'd1;
   localparam logic [1:0] StatusEmpty    = 2'd2;
   localparam logic [1:0] StatusNotFound = 2'd3;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] item_code;
      logic [7:0]  item_age;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_code;
      logic [7:0]  out_age;
      logic [7:0]  max_age;
      logic [7:0]  min_age;
      logic [15:0] mean_age;
      logic [4:0]  count;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] code;
      logic [7:0]  age;
   } record_type;

   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;
endpackage
`default_nettype wire

// ===== hw/rtl/bse_divider.sv =====
// Restoring divider for the mean age, one quotient bit per cycle.
// Depends on bse_pkg.
`default_nettype none
module bse_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bse_pkg::div_req_type div_req,
   output logic                   done,
   output logic [15:0]            quotient
);
   import bse_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;
   logic [16:0] diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done = 1'b0;
      trial = {rem_ff, quot_ff[31]};
      diff = trial - {1'b0, den_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in = '0;
         den_in = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[15:0];
            quot_in[0] = 1'b1;
         end else begin
            rem_in = trial[15:0];
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd31) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end
   assign quotient = quot_in[15:0];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/bounded_stack_engine_unit.sv =====
// Top level of the bounded stack engine: sequencer and record memory.
// Depends on bse_pkg and bse_divider.
`default_nettype none
// A command word is taken on req_word when start is high and busy is low.
// Each result word appears on rsp_word for one cycle with rsp_valid high;
// the receiver cannot stall and must take every word as it comes.
// Push, clear, sort of fewer than two records and the refused or empty cases
// register their word and show it from the reply state. Pop reads the top
// entry, takes the registered read data in the pop-wait state and then shows
// its word from the reply state. Search reads the store from top to bottom,
// one entry a cycle, and gives one word per match, or a not-found word if
// none matches; the final word is shown from the search-end state.
// Sort runs a bubble sort through the single memory port: a compare passes
// through states A, B and C, and a swap adds the write state W.
// Stats reads every entry once, then runs a 32-step divider for the mean.
// Reset empties the stack by clearing the count; the memory is not cleared,
// since only entries below the count are ever read. Busy falls in the cycle
// in which the final word is shown, so the next command may be taken at the
// same edge as that word; one command is at work at a time.
module bounded_stack_engine_unit #(
   parameter int DEPTH = bse_pkg::DefaultDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bse_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   output bse_pkg::rsp_word_type      rsp_word
);
   import bse_pkg::*;

   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int SumW = CntW + 8;

   localparam logic [3:0] StIdle    = 4'd0;
   localparam logic [3:0] StReply   = 4'd1;
   localparam logic [3:0] StPopWait = 4'd2;
   localparam logic [3:0] StSearch  = 4'd3;
   localparam logic [3:0] StSortA   = 4'd4;
   localparam logic [3:0] StSortB   = 4'd5;
   localparam logic [3:0] StSortC   = 4'd6;
   localparam logic [3:0] StSortW   = 4'd7;
   localparam logic [3:0] StStats   = 4'd8;
   localparam logic [3:0] StDiv     = 4'd9;
   localparam logic [3:0] StSearchE = 4'd10;

   // Record memory: one port, registered read.
   record_type mem [DEPTH];
   record_type rd_data_ff;
   logic [AddrWidth-1:0] mem_addr;
   logic mem_we;
   record_type mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   logic [3:0] state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;   // walk index
   logic [CntW-1:0] pass_ff, pass_in; // sort pass bound
   logic            rdv_ff, rdv_in;   // a read was issued last cycle
   logic [15:0]     code_ff, code_in; // code searched for
   record_type      hold_ff, hold_in;
   rsp_word_type    rsp_ff, rsp_in;
   logic            rspv_ff, rspv_in;
   logic [7:0]      max_ff, max_in, min_ff, min_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic            pend_ff, pend_in; // match held until the next match or the end of the search
   record_type      pend_rec_ff, pend_rec_in;

   div_req_type div_req;
   logic        div_done;
   logic [15:0] div_q;

   bse_divider u_div (
      .clock(clock), .reset(reset), .div_req(div_req),
      .done(div_done), .quotient(div_q)
   );

   function automatic rsp_word_type make_rsp(logic [1:0] st, logic [CntW-1:0] cnt);
      rsp_word_type r;
      r = '0;
      r.status = st;
      r.count = CountWidth'(cnt);
      r.last = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pass_in = pass_ff;
      rdv_in = 1'b0;
      code_in = code_ff;
      hold_in = hold_ff;
      rsp_in = rsp_ff;
      rspv_in = 1'b0;
      max_in = max_ff;
      min_in = min_ff;
      sum_in = sum_ff;
      pend_in = pend_ff;
      pend_rec_in = pend_rec_ff;
      mem_addr = '0;
      mem_we = 1'b0;
      mem_wdata = '0;
      div_req = '0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               code_in = req_word.item_code;
               state_in = StReply;
               case (req_word.func)
                  FuncPush: begin
                     if (count_ff >= CntW'(DEPTH)) begin
                        rsp_in = make_rsp(StatusFull, count_ff);
                     end else begin
                        mem_addr = AddrWidth'(count_ff);
                        mem_we = 1'b1;
                        mem_wdata = '{code: req_word.item_code, age: req_word.item_age};
                        count_in = count_ff + 1'b1;
                        rsp_in = make_rsp(StatusOk, count_in);
                     end
                  end
                  FuncPop: begin
                     if (count_ff == '0) begin
                        rsp_in = make_rsp(StatusEmpty, count_ff);
                     end else begin
                        mem_addr = AddrWidth'(count_ff - 1'b1);
                        count_in = count_ff - 1'b1;
                        state_in = StPopWait;
                     end
                  end
                  FuncClear: begin
                     count_in = '0;
                     rsp_in = make_rsp(StatusOk, '0);
                  end
                  FuncSearch: begin
                     if (count_ff == '0) begin
                        rsp_in = make_rsp(StatusEmpty, count_ff);
                     end else begin
                        idx_in = count_ff;
                        pend_in = 1'b0;
                        state_in = StSearch;
                     end
                  end
                  FuncSort: begin
                     if (count_ff < CntW'(2)) begin
                        rsp_in = make_rsp(StatusOk, count_ff);
                     end else begin
                        pass_in = count_ff - 1'b1;
                        idx_in = '0;
                        state_in = StSortA;
                     end
                  end
                  FuncStats: begin
                     if (count_ff == '0) begin
                        rsp_in = make_rsp(StatusEmpty, count_ff);
                     end else begin
                        idx_in = '0;
                        max_in = '0;
                        min_in = 8'hFF;
                        sum_in = '0;
                        state_in = StStats;
                     end
                  end
                  default: begin
                     state_in = StIdle;
                  end
               endcase
            end
         end
         StReply: begin
            rspv_in = 1'b1;
            state_in = StIdle;
         end
         StPopWait: begin
            rsp_in = make_rsp(StatusOk, count_ff);
            rsp_in.out_code = rd_data_ff.code;
            rsp_in.out_age = rd_data_ff.age;
            state_in = StReply;
         end
         StSearch: begin
            // Issue a read of the next entry down, and check the one read last cycle.
            if (idx_ff != '0) begin
               mem_addr = AddrWidth'(idx_ff - 1'b1);
               rdv_in = 1'b1;
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = StSearchE;
            end
            if (rdv_ff && rd_data_ff.code == code_ff) begin
               if (pend_ff) begin
                  rsp_in = make_rsp(StatusOk, count_ff);
                  rsp_in.out_code = pend_rec_ff.code;
                  rsp_in.out_age = pend_rec_ff.age;
                  rsp_in.last = 1'b0;
                  rspv_in = 1'b1;
               end
               pend_in = 1'b1;
               pend_rec_in = rd_data_ff;
            end
         end
         StSearchE: begin
            // The held match, if any, is the final one.
            if (pend_ff) begin
               rsp_in = make_rsp(StatusOk, count_ff);
               rsp_in.out_code = pend_rec_ff.code;
               rsp_in.out_age = pend_rec_ff.age;
            end else begin
               rsp_in = make_rsp(StatusNotFound, count_ff);
            end
            rspv_in = 1'b1;
            state_in = StIdle;
         end
         StSortA: begin
            mem_addr = AddrWidth'(idx_ff);
            state_in = StSortB;
         end
         StSortB: begin
            hold_in = rd_data_ff;
            mem_addr = AddrWidth'(idx_ff + 1'b1);
            state_in = StSortC;
         end
         StSortC: begin
            if (hold_ff.code > rd_data_ff.code) begin
               mem_addr = AddrWidth'(idx_ff);
               mem_we = 1'b1;
               mem_wdata = rd_data_ff;
               state_in = StSortW;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = StSortA;
               if (idx_ff + 1'b1 >= pass_ff) begin
                  idx_in = '0;
                  pass_in = pass_ff - 1'b1;
                  if (pass_ff == CntW'(1)) begin
                     rsp_in = make_rsp(StatusOk, count_ff);
                     state_in = StReply;
                  end
               end
            end
         end
         StSortW: begin
            mem_addr = AddrWidth'(idx_ff + 1'b1);
            mem_we = 1'b1;
            mem_wdata = hold_ff;
            // The larger record moves up and is the next left operand.
            idx_in = idx_ff + 1'b1;
            state_in = StSortA;
            if (idx_ff + 1'b1 >= pass_ff) begin
               idx_in = '0;
               pass_in = pass_ff - 1'b1;
               if (pass_ff == CntW'(1)) begin
                  rsp_in = make_rsp(StatusOk, count_ff);
                  state_in = StReply;
               end
            end
         end
         StStats: begin
            if (idx_ff < count_ff) begin
               mem_addr = AddrWidth'(idx_ff);
               rdv_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (rd_data_ff.age > max_ff) max_in = rd_data_ff.age;
               if (rd_data_ff.age < min_ff) min_in = rd_data_ff.age;
               sum_in = sum_ff + SumW'(rd_data_ff.age);
            end
            if (idx_ff >= count_ff && !rdv_ff) begin
               div_req.start = 1'b1;
               div_req.dividend = 32'({sum_ff, 8'd0});
               div_req.divisor = 16'(count_ff);
               state_in = StDiv;
            end
         end
         StDiv: begin
            if (div_done) begin
               rsp_in = make_rsp(StatusOk, count_ff);
               rsp_in.max_age = max_ff;
               rsp_in.min_age = min_ff;
               rsp_in.mean_age = div_q;
               state_in = StReply;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pass_ff <= pass_in;
      code_ff <= code_in;
      hold_ff <= hold_in;
      rsp_ff <= rsp_in;
      max_ff <= max_in;
      min_ff <= min_in;
      sum_ff <= sum_in;
      pend_rec_ff <= pend_rec_in;
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
         rdv_ff <= 1'b0;
         rspv_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff <= rdv_in;
         rspv_ff <= rspv_in;
         pend_ff <= pend_in;
      end
   end

   assign busy = (state_ff != StIdle);
   assign rsp_valid = rspv_ff;
   assign rsp_word = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH)) else $error("count exceeds depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && state_ff != StReply) |-> !rspv_in || state_ff == StSearch
      || state_ff == StSearchE) else $error("result outside reply");
   a_sort_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StSortA) |=> $stable(count_ff)) else $error("sort changed count");
endmodule
`default_nettype wire
